FILE: src/lphs_pkg.sv
// Package for the linear probe hash set: sizes, codes, state and bus types.
`default_nettype none

package lphs_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int ITEM_W      = 32;
    localparam int LIMIT_W     = 9;
    localparam int HASH_ROT    = 7;
    localparam int FOLD_SHIFT  = 16;
    localparam int BYTE_W      = 8;
    localparam int BYTES       = ITEM_W / BYTE_W;
    localparam int BIDX_W      = $clog2(BYTES);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);
    localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(TABLE_SLOTS);

    // APB register map
    localparam int               APB_AW         = 3;
    localparam logic [APB_AW-1:0] REG_PROBE_LIMIT = 3'd0;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_FIND  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_FOLD,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              we;
        logic              clr;
        logic [SLOT_W-1:0] addr;
        logic [ITEM_W-1:0] key;
        logic [ITEM_W-1:0] item;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [ITEM_W-1:0] key;
        logic [ITEM_W-1:0] item;
    } t_mem_rsp;

endpackage

`default_nettype wire

FILE: src/linear_probe_hash_set.sv
// Top level of the linear probe hash set: sequencer, shared adder, APB and stream ports.
`default_nettype none

// Open-addressing set of 256 slots holding 32-bit items. One transfer on the
// input stream carries an operation in s_tuser (0 clear, 1 add, 2 find) and
// the item in s_tdata; each operation yields exactly one result transfer
// (status in m_tdata[0], slot index in m_tdata[8:1]). The block handles one
// operation at a time. Clear and an unknown operation go straight from
// accept to the result step. Add and find probe from one slot up to the
// probe window: the rotate-add hash is computed one byte at a time over
// the item's four bytes, then folded, and every probe costs a registered
// slot-memory read plus a compare step on the single memory port. The
// next operation can be accepted in the same cycle that the result is
// posted. A result that waits on m_tready holds back the next operation
// only at its final step. Slot valid flags are flops, so clear and reset
// take effect at once. probe_limit (APB address 0) is sampled when an
// operation is accepted; 0 acts as 1 and values above 256 act as 256.

module linear_probe_hash_set
    import lphs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [31:0] item_value
    input  wire logic [1:0]        s_tuser,   // [1:0] op
    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [15:0]            m_tdata,   // [0] status, [8:1] slot_index, rest zero
    // APB configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [ITEM_W-1:0]   r_item, n_item;
    logic [ITEM_W-1:0]   r_hash, n_hash;
    logic [BIDX_W-1:0]   r_byte_idx, n_byte_idx;
    logic [SLOT_W-1:0]   r_addr, n_addr;
    logic [LIMIT_W-1:0]  r_left, n_left;
    logic                r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic                r_out_valid, n_out_valid;
    logic                r_out_status, n_out_status;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic [LIMIT_W-1:0]  r_probe_limit;

    logic                s_accept;
    logic                cfg_write;
    logic [LIMIT_W-1:0]  window;
    logic [BYTE_W-1:0]   cur_byte;
    logic [ITEM_W-1:0]   alu_a, alu_b, alu_sum;
    logic [ITEM_W-1:0]   folded;
    logic                hit;
    logic                out_free;
    t_mem_req            mem_req;
    t_mem_rsp            mem_rsp;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_PROBE_LIMIT);
    assign prdata    = (paddr == REG_PROBE_LIMIT) ? 32'(r_probe_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_limit <= LIMIT_RESET;
        end else if (cfg_write) begin
            r_probe_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    // probe window: at least one slot, at most the table
    always_comb begin
        priority if (r_probe_limit == '0) begin
            window = LIMIT_W'(1);
        end else if (r_probe_limit > LIMIT_MAX) begin
            window = LIMIT_MAX;
        end else begin
            window = r_probe_limit;
        end
    end

    // ---------------- handshakes ----------------
    assign s_tready = (r_state == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;

    assign m_tvalid = r_out_valid;
    assign m_tdata  = 16'({r_out_slot, r_out_status});

    // ---------------- shared adder ----------------
    // hash steps: rotl7 + byte; fold: h + (h >> 16); probe: slot + 1
    assign cur_byte = r_item[r_byte_idx*BYTE_W +: BYTE_W];

    always_comb begin
        unique case (r_state)
            S_HASH: begin
                alu_a = (r_hash << HASH_ROT) | (r_hash >> (ITEM_W - HASH_ROT));
                alu_b = ITEM_W'(cur_byte);
            end
            S_FOLD: begin
                alu_a = r_hash;
                alu_b = r_hash >> FOLD_SHIFT;
            end
            S_CMP: begin
                alu_a = ITEM_W'(r_addr);
                alu_b = ITEM_W'(1);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + alu_b;
    // a zero hash becomes one, so no key is zero; empty slots are marked by the valid flags
    assign folded  = (alu_sum == '0) ? ITEM_W'(1) : alu_sum;

    // add wants an empty slot; find wants key and item both equal
    assign hit = (r_op == OP_ADD) ? !mem_rsp.valid
                                  : (mem_rsp.valid && (mem_rsp.key == r_hash)
                                     && (mem_rsp.item == r_item));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == OP_ADD || s_tuser == OP_FIND) begin
                        n_state = S_HASH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_HASH: begin
                if (r_byte_idx == BIDX_W'(BYTES - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: n_state = S_READ;
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (hit || r_left == LIMIT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_op         = r_op;
        n_item       = r_item;
        n_hash       = r_hash;
        n_byte_idx   = r_byte_idx;
        n_addr       = r_addr;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !m_tready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        mem_req      = '0;
        mem_req.addr = r_addr;
        mem_req.key  = r_hash;
        mem_req.item = r_item;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_op         = t_op'(s_tuser);
                    n_item       = s_tdata;
                    n_hash       = '0;
                    n_byte_idx   = '0;
                    n_left       = window;
                    n_res_slot   = '0;
                    // unknown op reports failure and changes nothing
                    n_res_status = (s_tuser != OP_CLEAR);
                    mem_req.clr  = (s_tuser == OP_CLEAR);
                end
            end
            S_HASH: begin
                n_hash     = alu_sum;
                n_byte_idx = r_byte_idx + BIDX_W'(1);
            end
            S_FOLD: begin
                n_hash = folded;
                n_addr = folded[SLOT_W-1:0];
            end
            S_READ: begin
                // memory reads r_addr; data arrives in S_CMP
            end
            S_CMP: begin
                if (hit) begin
                    mem_req.we   = (r_op == OP_ADD);
                    n_res_status = 1'b0;
                    n_res_slot   = r_addr;
                end else if (r_left == LIMIT_W'(1)) begin
                    n_res_status = 1'b1;
                    n_res_slot   = '0;
                end else begin
                    n_addr = alu_sum[SLOT_W-1:0];
                    n_left = r_left - LIMIT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_item       <= n_item;
        r_hash       <= n_hash;
        r_byte_idx   <= n_byte_idx;
        r_addr       <= n_addr;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

    lphs_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rsp   (mem_rsp)
    );

    // ---------------- assertions ----------------
    a_fail_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[8:1] == '0))
        else $error("failed result carries nonzero slot");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CMP) |-> (r_left != '0 && r_left <= LIMIT_MAX))
        else $error("probe count out of range");

    a_add_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && r_op == OP_ADD && !mem_rsp.valid) |-> mem_req.we)
        else $error("add found empty slot but did not store");

    a_key_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CMP) |-> (r_hash != '0))
        else $error("probe with zero hash key");

endmodule

`default_nettype wire

FILE: src/lphs_slot_store.sv
// Slot storage: key and item memories with per-slot valid flops.
`default_nettype none

module lphs_slot_store
    import lphs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mem_req i_req,
    output t_mem_rsp      o_rsp
);

    logic [ITEM_W-1:0]      r_key_mem  [TABLE_SLOTS];
    logic [ITEM_W-1:0]      r_item_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [ITEM_W-1:0]      r_rd_key;
    logic [ITEM_W-1:0]      r_rd_item;
    logic                   r_rd_valid;

    // valid bits: clear empties every slot together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_key_mem[i_req.addr]  <= i_req.key;
            r_item_mem[i_req.addr] <= i_req.item;
        end
        r_rd_key   <= r_key_mem[i_req.addr];
        r_rd_item  <= r_item_mem[i_req.addr];
        r_rd_valid <= r_valid[i_req.addr];
    end

    assign o_rsp.valid = r_rd_valid;
    assign o_rsp.key   = r_rd_key;
    assign o_rsp.item  = r_rd_item;

endmodule

`default_nettype wire
